@@ sv/lru_pkg.sv @@
// Shared constants, types and sequencer states for the LRU page replacement unit.
// No dependencies; every other file in this block imports this package.
package lru_pkg;

  // Sizing of the frame table and the counters.
  localparam int FRAMES     = 16;
  localparam int PAGE_BITS  = 16;
  localparam int STAMP_BITS = 32;
  localparam int FAULT_BITS = 32;
  localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Fixed port widths.
  localparam int CFG_W  = 5;
  localparam int SLOT_W = 4;
  localparam int EVP_W  = 16;

  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(16);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } lru_state_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // What the scan unit has found so far.
  typedef struct packed {
    logic                 match_now;
    logic                 hit_found;
    logic [IDX_W-1:0]     hit_idx;
    logic                 empty_found;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } scan_res_t;

  // One write into the frame table.
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      idx;
    logic [PAGE_BITS-1:0]  page;
    logic [STAMP_BITS-1:0] stamp;
  } store_wr_t;

endpackage

@@ sv/lru_page_replacement_unit.sv @@
// LRU page replacement unit, top level: sequencer, counters and result register.
// Depends on lru_pkg, lru_store and lru_scan.
//
// Usage:
//   Input channel (in_valid, in_stall, in_page) carries one page reference per
//   transfer. Result channel (out_valid, out_stall, out_*) returns one result
//   per reference: hit flag, frame used, evicted page, fault total and the
//   stamp saturation flag. cfg_we/cfg_wdata write frames_in_use while idle.
// Timing:
//   A reference is taken only when the unit is idle. The frames in use are
//   scanned one per cycle, stopping early on a hit. An update state follows,
//   then the result is shown. The next reference is taken the cycle after the
//   result transfer at the earliest, so a new reference is not taken before
//   the result of the last one has been transferred.
// Reset:
//   All frames empty, counters zero, frames_in_use = 16.
// Stall:
//   While out_stall is high the result holds and no new reference is taken.
module lru_page_replacement_unit import lru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  in_page,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [SLOT_W-1:0]     out_slot,
  output logic                  out_evicted_valid,
  output logic [EVP_W-1:0]      out_evicted_page,
  output logic [FAULT_BITS-1:0] out_fault_total,
  output logic                  out_stamp_saturated
);

  lru_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      cfg_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      last_idx;
  logic [PAGE_BITS-1:0]  page_r;
  logic [STAMP_BITS-1:0] use_cnt_r, use_cnt_nxt;
  logic [FAULT_BITS-1:0] fault_cnt_r, fault_cnt_nxt;

  logic                  hit_r;
  logic [IDX_W-1:0]      slot_r;
  logic                  ev_valid_r;
  logic [PAGE_BITS-1:0]  ev_page_r;

  logic                  rd_valid;
  logic [PAGE_BITS-1:0]  rd_page;
  logic [STAMP_BITS-1:0] rd_stamp;
  scan_ctl_t             scan_ctl;
  scan_res_t             scan_res;
  store_wr_t             store_wr;

  logic                  upd_miss;
  logic                  upd_evict;
  logic [IDX_W-1:0]      upd_slot;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Last frame searched: a count of zero acts as one, a count above the table as its size.
  always_comb begin
    priority if (cfg_r == '0) begin
      last_idx = '0;
    end else if (int'(cfg_r) > FRAMES) begin
      last_idx = IDX_W'(FRAMES - 1);
    end else begin
      last_idx = IDX_W'(cfg_r - CFG_W'(1));
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.match_now || (idx_r == last_idx)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Choice of frame and eviction, settled in the update cycle.
  assign upd_miss  = !scan_res.hit_found;
  assign upd_evict = upd_miss && !scan_res.empty_found;
  always_comb begin
    priority if (scan_res.hit_found) begin
      upd_slot = scan_res.hit_idx;
    end else if (scan_res.empty_found) begin
      upd_slot = scan_res.empty_idx;
    end else begin
      upd_slot = scan_res.best_idx;
    end
  end

  // Saturating counters.
  assign use_cnt_nxt   = (use_cnt_r == STAMP_MAX) ? use_cnt_r : use_cnt_r + 1'b1;
  assign fault_cnt_nxt = (upd_miss && (fault_cnt_r != FAULT_MAX)) ?
                         fault_cnt_r + 1'b1 : fault_cnt_r;

  // Sequencer outputs.
  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    out_valid      = (state_r == ST_OUT);
    scan_ctl.clear = (state_r == ST_IDLE);
    scan_ctl.step  = (state_r == ST_SCAN);
    store_wr.we    = (state_r == ST_UPDATE);
    store_wr.idx   = upd_slot;
    store_wr.page  = page_r;
    store_wr.stamp = use_cnt_nxt;
  end

  // Scan pointer and the referenced page.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (state_r == ST_IDLE) begin
      idx_r <= '0;
    end else if (state_r == ST_SCAN) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      page_r <= in_page;
    end
  end

  // Counters update once per reference, in the update cycle; the fault count rises only on a miss.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_cnt_r   <= '0;
      fault_cnt_r <= '0;
    end else if (state_r == ST_UPDATE) begin
      use_cnt_r   <= use_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
    end
  end

  // Result register, held through a stalled transfer.
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      hit_r      <= scan_res.hit_found;
      slot_r     <= upd_slot;
      ev_valid_r <= upd_evict;
      ev_page_r  <= upd_evict ? scan_res.best_page : '0;
    end
  end

  assign out_hit             = hit_r;
  assign out_slot            = SLOT_W'(slot_r);
  assign out_evicted_valid   = ev_valid_r;
  assign out_evicted_page    = EVP_W'(ev_page_r);
  assign out_fault_total     = fault_cnt_r;
  assign out_stamp_saturated = (use_cnt_r == STAMP_MAX);

  lru_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .wr       (store_wr),
    .rd_valid (rd_valid),
    .rd_page  (rd_page),
    .rd_stamp (rd_stamp)
  );

  lru_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .idx      (idx_r),
    .page     (page_r),
    .rd_valid (rd_valid),
    .rd_page  (rd_page),
    .rd_stamp (rd_stamp),
    .res      (scan_res)
  );

  // A hit never reports an evicted page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_evicted_valid && (out_evicted_page == '0)))
    else $error("hit result reports an eviction");

  // The unit never takes a reference while a result is waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input ready while result pending");

  // The fault total never goes down.
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (fault_cnt_r >= $past(fault_cnt_r)))
    else $error("fault count decreased");

  // Once saturated, the stamp counter stays saturated.
  a_stamp_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_stamp_saturated |=> out_stamp_saturated)
    else $error("stamp saturation flag dropped");

  // The frame used lies inside the frames in use.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (slot_r <= last_idx))
    else $error("result frame outside the frames in use");

endmodule

@@ sv/lru_store.sv @@
// Frame table: page number, use stamp and valid bit for every frame.
// Depends on lru_pkg. One read port at the scan index, one write port.
module lru_store import lru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IDX_W-1:0]      rd_idx,
  input  store_wr_t             wr,
  output logic                  rd_valid,
  output logic [PAGE_BITS-1:0]  rd_page,
  output logic [STAMP_BITS-1:0] rd_stamp
);

  logic [FRAMES-1:0]     valid_r;
  logic [PAGE_BITS-1:0]  page_mem [FRAMES];
  logic [STAMP_BITS-1:0] stamp_mem [FRAMES];

  // Valid bits are cleared at reset; a frame becomes valid when first filled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  // Page and stamp contents hold no reset value; they are read only while valid.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      page_mem[wr.idx]  <= wr.page;
      stamp_mem[wr.idx] <= wr.stamp;
    end
  end

  // The frame under the scan pointer.
  assign rd_valid = valid_r[rd_idx];
  assign rd_page  = page_mem[rd_idx];
  assign rd_stamp = stamp_mem[rd_idx];

endmodule

@@ sv/lru_scan.sv @@
// Scan unit: one shared page compare and stamp compare, applied to one frame a cycle.
// Depends on lru_pkg. Tracks the first hit, the first empty frame and the oldest frame.
module lru_scan import lru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scan_ctl_t             ctl,
  input  logic [IDX_W-1:0]      idx,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic                  rd_valid,
  input  logic [PAGE_BITS-1:0]  rd_page,
  input  logic [STAMP_BITS-1:0] rd_stamp,
  output scan_res_t             res
);

  logic                  hit_found_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic                  empty_found_r;
  logic [IDX_W-1:0]      empty_idx_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [PAGE_BITS-1:0]  best_page_r;
  logic [STAMP_BITS-1:0] best_stamp_r;

  logic page_eq;
  logic stamp_lt;
  logic take_best;

  // The shared comparators. The first frame always seeds the oldest-frame search;
  // a strict compare keeps ties on the lowest index.
  assign page_eq   = rd_valid && (rd_page == page);
  assign stamp_lt  = rd_stamp < best_stamp_r;
  assign take_best = (idx == '0) || stamp_lt;

  // Flags for the hit and the first empty frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (ctl.clear) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (ctl.step) begin
      if (page_eq && !hit_found_r) begin
        hit_found_r <= 1'b1;
      end
      if (!rd_valid && !empty_found_r) begin
        empty_found_r <= 1'b1;
      end
    end
  end

  // Indices and the oldest frame's stamp and page.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (page_eq && !hit_found_r) begin
        hit_idx_r <= idx;
      end
      if (!rd_valid && !empty_found_r) begin
        empty_idx_r <= idx;
      end
      if (take_best) begin
        best_idx_r   <= idx;
        best_page_r  <= rd_page;
        best_stamp_r <= rd_stamp;
      end
    end
  end

  assign res.match_now   = page_eq;
  assign res.hit_found   = hit_found_r;
  assign res.hit_idx     = hit_idx_r;
  assign res.empty_found = empty_found_r;
  assign res.empty_idx   = empty_idx_r;
  assign res.best_idx    = best_idx_r;
  assign res.best_page   = best_page_r;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for lru_page_replacement_unit: a driver and a monitor
// around the unit, with an in-house LRU predictor checking every result transfer.
// Depends on lru_pkg and the RTL of the unit; needs no other files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lru_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AFTER   = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 125;

  // One result transfer, as predicted or as seen on the ports.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_W-1:0]     slot;
    logic                  ev_valid;
    logic [EVP_W-1:0]      ev_page;
    logic [FAULT_BITS-1:0] fault_total;
    logic                  stamp_sat;
  } lru_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PAGE_BITS-1:0]  in_page = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [SLOT_W-1:0]     out_slot;
  logic                  out_evicted_valid;
  logic [EVP_W-1:0]      out_evicted_page;
  logic [FAULT_BITS-1:0] out_fault_total;
  logic                  out_stamp_saturated;

  // Predictor copy of the frame table, counters and frame-count register.
  logic [PAGE_BITS-1:0]  frame_pg [FRAMES];
  logic                  frame_vld [FRAMES];
  logic [STAMP_BITS-1:0] frame_stp [FRAMES];
  logic [STAMP_BITS-1:0] use_ctr = '0;
  logic [FAULT_BITS-1:0] fault_ctr = '0;
  logic [CFG_W-1:0]      frames_cfg = CFG_RESET;

  logic [PAGE_BITS-1:0] pending_pages [$];
  lru_result_t          expected_results [$];

  int  send_idle_pct = 29;
  int  recv_idle_pct = 60;
  int  accepted_refs = 0;
  int  checked = 0;
  int  hits = 0;
  int  faults = 0;
  int  evictions = 0;
  int  errors = 0;
  int  cfg_writes = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  in_taken = 1'b0;

  lru_page_replacement_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_page             (in_page),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_fault_total     (out_fault_total),
    .out_stamp_saturated (out_stamp_saturated)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < FRAMES; k++) frame_vld[k] = 1'b0;
  end

  // Works out the result of one page reference and updates the predicted state.
  function automatic lru_result_t predict_access(input logic [PAGE_BITS-1:0] ref_page);
    lru_result_t           r;
    int                    n;
    int                    sel;
    bit                    found;
    bit                    empty;
    logic [STAMP_BITS-1:0] best;
    r = '0;
    sel = 0;
    found = 1'b0;
    empty = 1'b0;
    // A frame count of zero behaves as one, anything above the table as the table.
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
    for (int k = 0; k < n; k++) begin
      if (!found && frame_vld[k] && frame_pg[k] == ref_page) begin
        found = 1'b1;
        sel = k;
      end
    end
    if (!found) begin
      for (int k = 0; k < n; k++) begin
        if (!empty && !frame_vld[k]) begin
          empty = 1'b1;
          sel = k;
        end
      end
      // With no empty frame the oldest stamp loses; ties keep the lowest index.
      if (!empty) begin
        best = frame_stp[0];
        sel = 0;
        for (int k = 1; k < n; k++) begin
          if (frame_stp[k] < best) begin
            best = frame_stp[k];
            sel = k;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page = frame_pg[sel];
      end
      frame_pg[sel] = ref_page;
      frame_vld[sel] = 1'b1;
      if (fault_ctr != FAULT_MAX) fault_ctr = fault_ctr + 1'b1;
    end
    if (use_ctr != STAMP_MAX) use_ctr = use_ctr + 1'b1;
    frame_stp[sel] = use_ctr;
    r.hit = found;
    r.slot = sel[SLOT_W-1:0];
    r.fault_total = fault_ctr;
    r.stamp_sat = (use_ctr == STAMP_MAX);
    return r;
  endfunction

  // Driver: offers the next pending page after each transfer, with random gaps.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && pending_pages.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_page <= pending_pages.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: random, plus one long hold-off so that the unit backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_refs >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: checks each result transfer, then predicts each accepted reference.
  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.hit = out_hit;
        got.slot = out_slot;
        got.ev_valid = out_evicted_valid;
        got.ev_page = out_evicted_page;
        got.fault_total = out_fault_total;
        got.stamp_sat = out_stamp_saturated;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("tb_top: result transfer with nothing pending");
        end else begin
          want = expected_results.pop_front();
          checked++;
          hits += want.hit;
          faults += !want.hit;
          evictions += want.ev_valid;
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("tb_top: result %0d expected hit=%0d slot=%0d ev=%0d/%h faults=%0d sat=%0d",
                       checked, want.hit, want.slot, want.ev_valid, want.ev_page,
                       want.fault_total, want.stamp_sat);
              $display("tb_top: result %0d actual   hit=%0d slot=%0d ev=%0d/%h faults=%0d sat=%0d",
                       checked, got.hit, got.slot, got.ev_valid, got.ev_page,
                       got.fault_total, got.stamp_sat);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_access(in_page));
        accepted_refs++;
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Waits until every reference has been offered, taken and answered.
  task automatic settle();
    while (pending_pages.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the frame count while the unit is idle.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    frames_cfg = value;
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reference string with locality: a working set of the frames in use plus up to
  // three pages, some immediate repeats and some fully random pages.
  task automatic queue_random(input int count);
    logic [PAGE_BITS-1:0] ws [20];
    logic [PAGE_BITS-1:0] pg;
    int                   ws_n;
    int                   roll;
    ws_n = ((frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg)))
           + $urandom_range(3);
    for (int k = 0; k < ws_n; k++) ws[k] = PAGE_BITS'($urandom);
    pg = ws[0];
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 70) pg = ws[$urandom_range(ws_n - 1)];
      else if (roll >= 85) pg = PAGE_BITS'($urandom);
      if ($urandom_range(15) == 0) ws[$urandom_range(ws_n - 1)] = PAGE_BITS'($urandom);
      pending_pages.push_back(pg);
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin
    logic [CFG_W-1:0] phase_frames [PHASES];
    phase_frames = '{5'd16, 5'd4, 5'd1, 5'd16, 5'd0, 5'd8, 5'd31, 5'd3, 5'd17};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset frame count: fill, hit, page extremes and alternating bit patterns.
    pending_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h0001,
                      16'h8000};
    // Shrunk to two frames: resident pages above the count must miss.
    write_frames(5'd2);
    pending_pages = '{16'h5555, 16'h0000, 16'h8000};
    // A count of zero behaves as a single frame.
    write_frames(5'd0);
    pending_pages = '{16'h1234, 16'h1234, 16'h4321};
    // Grown past the table: the old frames come back into the search.
    write_frames(5'd31);
    pending_pages = '{16'h0001, 16'hAAAA, 16'h7FFF, 16'hFFFE};
    write_frames(5'd17);
    pending_pages = '{16'h0001, 16'h7FFF};

    // Random phases: receiver idles more, then sender idles more, then no gaps.
    for (int p = 0; p < PHASES; p++) begin
      write_frames(phase_frames[p]);
      if (p == 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 29;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_random(PHASE_ITEMS);
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) errors++;
    $display("tb_top: %0d references checked: %0d hits, %0d faults, %0d evictions",
             checked, hits, faults, evictions);
    $display("tb_top: %0d frame-count writes from 0 to 31, one %0d-cycle result hold-off",
             cfg_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lru_pkg.sv
sv/lru_store.sv
sv/lru_scan.sv
sv/lru_page_replacement_unit.sv
test/tb_top.sv
